/* src/rgbyuv_pkg.sv */
package rgbyuv_pkg;

    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_REVERSED = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd320;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd240;
    localparam logic                  SCAN_REVERSED_RESET = 1'b1;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    // Weighted sums stay within +/-2^16, so 18 signed bits hold them
    localparam int unsigned SUM_W = 18;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma;
        logic       chroma_valid;
        logic       chroma_is_v;
        logic       frame_end;
    } result_t;

    // Classified pixel handed from the front to the back
    typedef struct packed {
        pixel_t pix;
        logic   chroma_valid;
        logic   chroma_is_v;
        logic   frame_end;
    } item_t;

    // Last index of a dimension: zero counts as one, oversize clips to the maximum
    function automatic logic [31:0] last_index(input logic [CFG_DATA_W-1:0] v,
                                               input int unsigned maxv);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return 32'd0;
        end else if (v32 > maxv) begin
            return 32'(maxv - 1);
        end else begin
            return v32 - 32'd1;
        end
    endfunction

endpackage

/* src/rgbyuv_front.sv */
module rgbyuv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rgbyuv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rgbyuv_pkg::pixel_t                s_pixel,
    output logic                              push_valid,
    input  logic                              push_ready,
    output rgbyuv_pkg::item_t                 push_item
);
    import rgbyuv_pkg::*;

    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic                  rev_reg, rev_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    logic             restart;
    logic             accept;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic             col_last, row_last, frame_end;
    logic             cvalid;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid & push_ready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        rev_next    = rev_reg;
        restart     = 1'b0;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH: begin
                    width_next = cfg_wdata;
                    restart    = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    height_next = cfg_wdata;
                    restart     = 1'b1;
                end
                REG_SCAN_REVERSED: begin
                    rev_next = cfg_wdata[0];
                    restart  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Start point of a frame under the settings in force next cycle
    assign last_col  = COL_W'(last_index(width_next, MAX_WIDTH));
    assign last_row  = ROW_W'(last_index(height_next, MAX_HEIGHT));
    assign start_col = rev_next ? last_col : '0;
    assign start_row = rev_next ? last_row : '0;

    assign cvalid   = ~col_reg[0];
    assign col_last = rev_reg ? (col_reg == '0) : (col_reg >= last_col);
    assign row_last = rev_reg ? (row_reg == '0) : (row_reg >= last_row);
    assign frame_end = col_last & row_last;

    always_comb begin
        push_item.pix          = s_pixel;
        push_item.chroma_valid = cvalid;
        push_item.chroma_is_v  = cvalid & row_reg[0];
        push_item.frame_end    = frame_end;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (restart) begin
            col_next = start_col;
            row_next = start_row;
        end else if (accept) begin
            priority if (frame_end) begin
                col_next = start_col;
                row_next = start_row;
            end else if (col_last) begin
                col_next = start_col;
                row_next = rev_reg ? row_reg - ROW_W'(1) : row_reg + ROW_W'(1);
            end else begin
                col_next = rev_reg ? col_reg - COL_W'(1) : col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
            rev_reg    <= SCAN_REVERSED_RESET;
            col_reg    <= SCAN_REVERSED_RESET ?
                          COL_W'(last_index(FRAME_WIDTH_RESET, MAX_WIDTH)) : '0;
            row_reg    <= SCAN_REVERSED_RESET ?
                          ROW_W'(last_index(FRAME_HEIGHT_RESET, MAX_HEIGHT)) : '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            rev_reg    <= rev_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

/* src/rgbyuv_queue.sv */
module rgbyuv_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  rgbyuv_pkg::item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output rgbyuv_pkg::item_t pop_item
);
    import rgbyuv_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];

    assign push = push_valid & push_ready;
    assign pop  = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/rgbyuv_back.sv */
module rgbyuv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  rgbyuv_pkg::item_t   pop_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rgbyuv_pkg::result_t m_result
);
    import rgbyuv_pkg::*;

    logic                    s1_valid_reg, s1_valid_next;
    logic signed [SUM_W-1:0] y_sum_reg, y_sum_next;
    logic signed [SUM_W-1:0] c_sum_reg, c_sum_next;
    logic                    cvalid_reg, isv_reg, fend_reg;
    logic                    out_valid_reg, out_valid_next;
    result_t                 result_reg, result_next;

    logic                    s1_load, out_load, out_ready;
    logic signed [SUM_W-1:0] rs, gs, bs;
    logic signed [SUM_W-1:0] u_sum, v_sum;

    assign out_ready = ~out_valid_reg | m_ready;
    assign pop_ready = ~s1_valid_reg | out_ready;
    assign s1_load   = pop_valid & pop_ready;
    assign out_load  = s1_valid_reg & out_ready;

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

    // Stage 1: weighted sums with the rounding offset
    assign rs = $signed({{(SUM_W-8){1'b0}}, pop_item.pix.red});
    assign gs = $signed({{(SUM_W-8){1'b0}}, pop_item.pix.green});
    assign bs = $signed({{(SUM_W-8){1'b0}}, pop_item.pix.blue});

    assign y_sum_next = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs + 18'sd128;
    assign u_sum      = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs + 18'sd128;
    assign v_sum      = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;
    assign c_sum_next = pop_item.chroma_is_v ? v_sum : u_sum;

    // Stage 2: floor shift by 8 is bits 15:8 of the two's complement sum
    always_comb begin
        result_next.luma         = y_sum_reg[15:8] + LUMA_OFFSET;
        result_next.chroma       = cvalid_reg ? (c_sum_reg[15:8] + CHROMA_OFFSET) : 8'd0;
        result_next.chroma_valid = cvalid_reg;
        result_next.chroma_is_v  = isv_reg;
        result_next.frame_end    = fend_reg;
    end

    assign s1_valid_next  = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            y_sum_reg  <= y_sum_next;
            c_sum_reg  <= c_sum_next;
            cvalid_reg <= pop_item.chroma_valid;
            isv_reg    <= pop_item.chroma_is_v;
            fend_reg   <= pop_item.frame_end;
        end
        if (out_load) begin
            result_reg <= result_next;
        end
    end

endmodule

/* src/rgb_to_yuv420_pixel_stream_top.sv */
// A result passes through a queue entry, the stage-1 sum registers and the result register.
// Throughput: one pixel per cycle while m_ready is high; a two-entry queue between the index counters and
// the two-stage arithmetic pipeline lets either side stall on its own.
// Reset (aresetn low, synchronous): width 320, height 240, reversed scan, indices
// at the frame start, queue and pipeline empty. Any write to a defined register restarts the frame.
module rgb_to_yuv420_pixel_stream_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rgbyuv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rgbyuv_pkg::pixel_t                s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rgbyuv_pkg::result_t               m_result
);
    import rgbyuv_pkg::*;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    rgbyuv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rgbyuv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rgbyuv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

/* src/rgbyuv_checker.sv */
module rgbyuv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_we,
    input logic [rgbyuv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                              s_valid,
    input logic                              s_ready,
    input rgbyuv_pkg::pixel_t                s_pixel,
    input logic                              m_valid,
    input logic                              m_ready,
    input rgbyuv_pkg::result_t               m_result
);
    import rgbyuv_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result beat changed while stalled");

    a_v_needs_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.chroma_is_v |-> m_result.chroma_valid)
        else $error("V flag set without a chroma sample");

    a_no_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.chroma_valid |-> m_result.chroma == 8'd0)
        else $error("chroma not zero on a luma-only beat");

    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result.luma >= 8'd16 && m_result.luma <= 8'd235)
        else $error("luma outside the studio range");

endmodule

bind rgb_to_yuv420_pixel_stream_top rgbyuv_checker u_checker (.*);
